[rtl/core/bzs_pkg.sv]
// ----------------------------------------------------------------------------
// Bezier spline package
// Beat types, fixed-point widths and the rounding and saturation helpers
// shared by the spline control-point solver.
// ----------------------------------------------------------------------------
`default_nettype none

package bzs_pkg;

   // Coordinate and internal fixed-point widths.
   localparam int COORD_BITS    = 24;               // Q.8 coordinates
   localparam int ACC_BITS      = COORD_BITS + 16;  // Q.16 sweep values
   localparam int WIDE_BITS     = ACC_BITS + 4;     // headroom for right-hand sides
   localparam int FRAC_GROW     = 8;                // Q.8 to Q.16
   localparam int COEF_BITS     = 16;               // sweep coefficient, Q.16, <= 0.5
   localparam int PIVOT_BITS    = 19;               // pivot, Q.16, below 8.0
   localparam int DIVIDEND_BITS = 33;               // 2^32 plus half the pivot
   localparam int ONE_Q16       = 65536;

   // Input beat: one knot.
   typedef struct packed {
      logic signed [COORD_BITS-1:0] knot_x;
      logic signed [COORD_BITS-1:0] knot_y;
      logic                         last_knot;
   } req_type;

   // Output beat: one curve segment.
   typedef struct packed {
      logic signed [COORD_BITS-1:0] ctrl1_x;
      logic signed [COORD_BITS-1:0] ctrl1_y;
      logic signed [COORD_BITS-1:0] ctrl2_x;
      logic signed [COORD_BITS-1:0] ctrl2_y;
      logic signed [COORD_BITS-1:0] end_x;
      logic signed [COORD_BITS-1:0] end_y;
      logic                         straight;
      logic                         dropped;
      logic                         last_segment;
   } rsp_type;

   // Q.8 coordinate to Q.16 in the wide format.
   function automatic logic signed [WIDE_BITS-1:0] knot_to_wide(
      logic signed [COORD_BITS-1:0] k);
      return {{(WIDE_BITS-COORD_BITS-FRAC_GROW){k[COORD_BITS-1]}}, k, {FRAC_GROW{1'b0}}};
   endfunction

   // Sign extension of a sweep value to the wide format.
   function automatic logic signed [WIDE_BITS-1:0] acc_to_wide(
      logic signed [ACC_BITS-1:0] a);
      return {{(WIDE_BITS-ACC_BITS){a[ACC_BITS-1]}}, a};
   endfunction

   // Saturate a wide value to the sweep width.
   function automatic logic signed [ACC_BITS-1:0] sat_acc(logic signed [WIDE_BITS-1:0] v);
      logic [WIDE_BITS-ACC_BITS:0] upper;
      upper = v[WIDE_BITS-1:ACC_BITS-1];
      if ((&upper) || !(|upper)) begin
         return v[ACC_BITS-1:0];
      end
      return v[WIDE_BITS-1] ? {1'b1, {(ACC_BITS-1){1'b0}}} : {1'b0, {(ACC_BITS-1){1'b1}}};
   endfunction

   // Saturate a wide value to the coordinate width.
   function automatic logic signed [COORD_BITS-1:0] sat_coord(
      logic signed [WIDE_BITS-1:0] v);
      logic [WIDE_BITS-COORD_BITS:0] upper;
      upper = v[WIDE_BITS-1:COORD_BITS-1];
      if ((&upper) || !(|upper)) begin
         return v[COORD_BITS-1:0];
      end
      return v[WIDE_BITS-1] ? {1'b1, {(COORD_BITS-1){1'b0}}}
                            : {1'b0, {(COORD_BITS-1){1'b1}}};
   endfunction

   // Shift right with rounding to nearest, ties away from zero.
   function automatic logic signed [WIDE_BITS-1:0] round_away(
      logic signed [WIDE_BITS-1:0] v, int shift);
      logic [WIDE_BITS-1:0] mag;
      logic [WIDE_BITS-1:0] r;
      mag = v[WIDE_BITS-1] ? -v : v;
      r   = (mag + (WIDE_BITS'(1) << (shift - 1))) >> shift;
      return v[WIDE_BITS-1] ? -r : r;
   endfunction

endpackage

`default_nettype wire

[rtl/core/bzs_ram.sv]
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module bzs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write, and registered read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[rtl/core/bzs_recip.sv]
// ----------------------------------------------------------------------------
// Pivot reciprocal unit
// Computes round(2^32 / pivot) by restoring division, one quotient bit per
// cycle. The done pulse comes with the result.
// ----------------------------------------------------------------------------
`default_nettype none

module bzs_recip (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [bzs_pkg::PIVOT_BITS-1:0]   pivot,
   output logic                             done,
   output logic [bzs_pkg::COEF_BITS-1:0]    recip
);
   import bzs_pkg::*;

   localparam int CNT_BITS = $clog2(DIVIDEND_BITS);

   logic                     run_ff, run_in;
   logic                     done_ff, done_in;
   logic [CNT_BITS-1:0]      cnt_ff, cnt_in;
   logic [PIVOT_BITS-1:0]    div_ff, div_in;
   logic [PIVOT_BITS-1:0]    rem_ff, rem_in;
   logic [DIVIDEND_BITS-1:0] num_ff, num_in;
   logic [COEF_BITS-1:0]     quo_ff, quo_in;
   logic [PIVOT_BITS:0]      trial;
   logic                     fits;

   // One restoring step: bring down the next dividend bit and try to subtract.
   always_comb begin
      trial  = {rem_ff, num_ff[DIVIDEND_BITS-1]};
      fits   = trial >= {1'b0, div_ff};
      run_in = run_ff;
      done_in = 1'b0;
      cnt_in = cnt_ff;
      div_in = div_ff;
      rem_in = rem_ff;
      num_in = num_ff;
      quo_in = quo_ff;
      if (start) begin
         run_in = 1'b1;
         cnt_in = '0;
         div_in = pivot;
         rem_in = '0;
         num_in = {1'b1, {(DIVIDEND_BITS-1){1'b0}}} | DIVIDEND_BITS'(pivot >> 1);
         quo_in = '0;
      end else if (run_ff) begin
         rem_in = fits ? PIVOT_BITS'(trial - {1'b0, div_ff}) : trial[PIVOT_BITS-1:0];
         num_in = num_ff << 1;
         quo_in = {quo_ff[COEF_BITS-2:0], fits};
         cnt_in = cnt_ff + CNT_BITS'(1);
         if (cnt_ff == CNT_BITS'(DIVIDEND_BITS - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   // Datapath.
   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      div_ff <= div_in;
      rem_ff <= rem_in;
      num_ff <= num_in;
      quo_ff <= quo_in;
   end

   assign done  = done_ff;
   assign recip = quo_ff;

endmodule

`default_nettype wire

[rtl/core/bzs_mul.sv]
// ----------------------------------------------------------------------------
// Coefficient multiplier
// Multiplies a signed Q.16 value by an unsigned Q.16 coefficient with
// shift and add, rounding the magnitude to nearest.
// ----------------------------------------------------------------------------
`default_nettype none

module bzs_mul (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic signed [bzs_pkg::WIDE_BITS-1:0] a,
   input  logic [bzs_pkg::COEF_BITS-1:0]        coef,
   output logic                                 done,
   output logic signed [bzs_pkg::WIDE_BITS-1:0] p
);
   import bzs_pkg::*;

   localparam int PROD_BITS = WIDE_BITS + COEF_BITS;
   localparam int CNT_BITS  = $clog2(COEF_BITS);

   logic                   run_ff, run_in;
   logic                   done_ff, done_in;
   logic [CNT_BITS-1:0]    cnt_ff, cnt_in;
   logic [PROD_BITS-1:0]   mag_ff, mag_in;
   logic [PROD_BITS-1:0]   acc_ff, acc_in;
   logic [COEF_BITS-1:0]   coef_ff, coef_in;
   logic                   neg_ff, neg_in;
   logic [WIDE_BITS-1:0]   a_mag;
   logic [WIDE_BITS-1:0]   res;

   // Add the shifted magnitude for each set coefficient bit, LSB first.
   always_comb begin
      a_mag   = a[WIDE_BITS-1] ? -a : a;
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      mag_in  = mag_ff;
      acc_in  = acc_ff;
      coef_in = coef_ff;
      neg_in  = neg_ff;
      if (start) begin
         run_in  = 1'b1;
         cnt_in  = '0;
         mag_in  = PROD_BITS'(a_mag);
         acc_in  = PROD_BITS'(1) << (COEF_BITS - 1);
         coef_in = coef;
         neg_in  = a[WIDE_BITS-1];
      end else if (run_ff) begin
         if (coef_ff[0]) begin
            acc_in = acc_ff + mag_ff;
         end
         mag_in  = mag_ff << 1;
         coef_in = coef_ff >> 1;
         cnt_in  = cnt_ff + CNT_BITS'(1);
         if (cnt_ff == CNT_BITS'(COEF_BITS - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   // Datapath.
   always_ff @(posedge clock) begin
      cnt_ff  <= cnt_in;
      mag_ff  <= mag_in;
      acc_ff  <= acc_in;
      coef_ff <= coef_in;
      neg_ff  <= neg_in;
   end

   // Drop the fraction and restore the sign.
   assign res  = acc_ff[PROD_BITS-1:COEF_BITS];
   assign p    = neg_ff ? -res : res;
   assign done = done_ff;

endmodule

`default_nettype wire

[rtl/core/bezier_spline_control_points.sv]
// ----------------------------------------------------------------------------
// Cubic Bezier spline control points
// Stores knots and solves the tridiagonal system for the control points of
// each segment with a forward and a backward Thomas sweep.
// ----------------------------------------------------------------------------
// Usage:
//   Knots enter on req_data when start is high and busy is low, one beat per
//   cycle while busy stays low. Knots past MAX_KNOTS are discarded and every
//   segment of that curve reports dropped. The knot with last_knot set raises
//   busy and starts the solve; busy stays high until the final segment leaves.
//   Results leave on rsp_data, one segment per beat, each valid for the single
//   cycle that rsp_strobe is high; the receiver cannot stall them.
//   With one or two knots, one straight segment comes out after the last knot.
//   With K knots (n = K-1 segments) each forward row waits on the reciprocal
//   divider and two multiplier passes, each backward row on two multiplier
//   passes, and the n segment beats follow the backward sweep.
//   Knots and sweep values live in two RAMs with registered reads.
//   Reset clears the knot count and the overflow mark; no RAM clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module bezier_spline_control_points #(
   parameter int MAX_KNOTS = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  bzs_pkg::req_type  req_data,
   output logic              rsp_strobe,
   output bzs_pkg::rsp_type  rsp_data
);
   import bzs_pkg::*;

   localparam int IDX_BITS = $clog2(MAX_KNOTS);
   localparam int CNT_BITS = $clog2(MAX_KNOTS + 1);
   localparam int KNOT_W   = 2 * COORD_BITS;
   localparam int SOLVE_W  = COEF_BITS + 2 * ACC_BITS;

   typedef enum logic [20:0] {
      ST_IDLE    = 21'h000001,
      ST_SM_RD0  = 21'h000002,
      ST_SM_RD1  = 21'h000004,
      ST_SM_OUT  = 21'h000008,
      ST_FWD_RD  = 21'h000010,
      ST_FWD_KI  = 21'h000020,
      ST_FWD_KN  = 21'h000040,
      ST_FWD_DIV = 21'h000080,
      ST_FWD_MX  = 21'h000100,
      ST_FWD_MXW = 21'h000200,
      ST_FWD_MY  = 21'h000400,
      ST_FWD_MYW = 21'h000800,
      ST_BWD_RD  = 21'h001000,
      ST_BWD_MX  = 21'h002000,
      ST_BWD_MXW = 21'h004000,
      ST_BWD_MY  = 21'h008000,
      ST_BWD_MYW = 21'h010000,
      ST_EM_RD0  = 21'h020000,
      ST_EM_CAP  = 21'h040000,
      ST_EM_RD   = 21'h080000,
      ST_EM_OUT  = 21'h100000
   } state_type;

   state_type                   state_ff, state_in;
   logic [CNT_BITS-1:0]         cnt_ff, cnt_in;
   logic                        ovf_ff, ovf_in;
   logic [IDX_BITS-1:0]         n_ff, n_in;
   logic [IDX_BITS-1:0]         row_ff, row_in;
   logic [KNOT_W-1:0]           ka_ff, ka_in;
   logic signed [WIDE_BITS-1:0] vx_ff, vx_in, vy_ff, vy_in;
   logic [COEF_BITS-1:0]        coef_ff, coef_in, cprev_ff, cprev_in;
   logic signed [ACC_BITS-1:0]  prevx_ff, prevx_in, prevy_ff, prevy_in;
   logic signed [ACC_BITS-1:0]  stx_ff, stx_in, sty_ff, sty_in;
   logic signed [ACC_BITS-1:0]  newx_ff, newx_in;
   logic                        rsp_strobe_ff, rsp_strobe_in;
   rsp_type                     rsp_data_ff, rsp_data_in;

   // RAM ports.
   logic                        k_we;
   logic [IDX_BITS-1:0]         k_raddr;
   logic [KNOT_W-1:0]           k_q;
   logic                        s_we;
   logic [SOLVE_W-1:0]          s_wdata;
   logic [IDX_BITS-1:0]         s_raddr;
   logic [SOLVE_W-1:0]          s_q;

   // Arithmetic units.
   logic                        div_start, div_done;
   logic [PIVOT_BITS-1:0]       pivot;
   logic [COEF_BITS-1:0]        recip;
   logic                        mul_start, mul_done;
   logic signed [WIDE_BITS-1:0] mul_a, mul_p;
   logic [COEF_BITS-1:0]        mul_coef;

   // Helper values.
   logic                        accept;
   logic [CNT_BITS-1:0]         cnt_next;
   logic                        first_row, last_row;
   logic signed [COORD_BITS-1:0] ka_x, ka_y, kq_x, kq_y;
   logic [COEF_BITS-1:0]        s_coef;
   logic signed [ACC_BITS-1:0]  s_x, s_y;
   logic signed [WIDE_BITS-1:0] rhs_x, rhs_y;
   logic signed [ACC_BITS-1:0]  sat_p;

   assign accept    = start && !busy;
   assign k_we      = accept && (cnt_ff < CNT_BITS'(MAX_KNOTS));
   assign first_row = row_ff == '0;
   assign last_row  = row_ff == (n_ff - IDX_BITS'(1));
   assign ka_x      = ka_ff[KNOT_W-1 -: COORD_BITS];
   assign ka_y      = ka_ff[COORD_BITS-1:0];
   assign kq_x      = k_q[KNOT_W-1 -: COORD_BITS];
   assign kq_y      = k_q[COORD_BITS-1:0];
   assign s_coef    = s_q[SOLVE_W-1 -: COEF_BITS];
   assign s_x       = s_q[2*ACC_BITS-1 -: ACC_BITS];
   assign s_y       = s_q[ACC_BITS-1:0];
   assign sat_p     = sat_acc(mul_p);

   // Right-hand side of a forward row, less the eliminated previous value.
   function automatic logic signed [WIDE_BITS-1:0] row_rhs(
      logic first, logic last, logic signed [COORD_BITS-1:0] ki,
      logic signed [COORD_BITS-1:0] kn, logic signed [ACC_BITS-1:0] prev);
      logic signed [WIDE_BITS-1:0] wi, wn, wp;
      wi = knot_to_wide(ki);
      wn = knot_to_wide(kn);
      wp = acc_to_wide(prev);
      if (first) begin
         return wi + (wn <<< 1);
      end
      if (last) begin
         return (wi <<< 3) + wn - (wp <<< 1);
      end
      return (wi <<< 2) + (wn <<< 1) - wp;
   endfunction

   assign rhs_x = row_rhs(first_row, last_row, ka_x, kq_x, prevx_ff);
   assign rhs_y = row_rhs(first_row, last_row, ka_y, kq_y, prevy_ff);

   // Pivot of the current forward row.
   always_comb begin
      priority if (first_row) begin
         pivot = PIVOT_BITS'(2 * ONE_Q16);
      end else if (last_row) begin
         pivot = PIVOT_BITS'(7 * ONE_Q16) - (PIVOT_BITS'(cprev_ff) << 1);
      end else begin
         pivot = PIVOT_BITS'(4 * ONE_Q16) - PIVOT_BITS'(cprev_ff);
      end
   end

   // Multiplier operand selection.
   always_comb begin
      mul_start = 1'b0;
      mul_a     = vx_ff;
      mul_coef  = coef_ff;
      unique case (state_ff)
         ST_FWD_MX: begin
            mul_start = 1'b1;
         end
         ST_FWD_MY: begin
            mul_start = 1'b1;
            mul_a     = vy_ff;
         end
         ST_BWD_MX: begin
            mul_start = 1'b1;
            mul_a     = acc_to_wide(prevx_ff);
            mul_coef  = s_coef;
         end
         ST_BWD_MY: begin
            mul_start = 1'b1;
            mul_a     = acc_to_wide(prevy_ff);
         end
         default: begin
         end
      endcase
   end

   // Sequencer: load, then either the straight segment or forward sweep, backward sweep, emit.
   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      ovf_in        = ovf_ff;
      n_in          = n_ff;
      row_in        = row_ff;
      ka_in         = ka_ff;
      vx_in         = vx_ff;
      vy_in         = vy_ff;
      coef_in       = coef_ff;
      cprev_in      = cprev_ff;
      prevx_in      = prevx_ff;
      prevy_in      = prevy_ff;
      stx_in        = stx_ff;
      sty_in        = sty_ff;
      newx_in       = newx_ff;
      rsp_strobe_in = 1'b0;
      rsp_data_in   = rsp_data_ff;
      cnt_next      = k_we ? cnt_ff + CNT_BITS'(1) : cnt_ff;
      k_raddr       = '0;
      s_raddr       = '0;
      s_we          = 1'b0;
      s_wdata       = {coef_ff, stx_ff, sat_p};
      div_start     = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cnt_in = cnt_next;
               ovf_in = ovf_ff || !k_we;
               row_in = '0;
               n_in   = IDX_BITS'(cnt_next - CNT_BITS'(1));
               if (req_data.last_knot) begin
                  state_in = (cnt_next <= CNT_BITS'(2)) ? ST_SM_RD0 : ST_FWD_RD;
               end
            end
         end
         ST_SM_RD0: begin
            state_in = ST_SM_RD1;
         end
         ST_SM_RD1: begin
            ka_in    = k_q;
            k_raddr  = (cnt_ff == CNT_BITS'(2)) ? IDX_BITS'(1) : '0;
            state_in = ST_SM_OUT;
         end
         ST_SM_OUT: begin
            rsp_strobe_in = 1'b1;
            rsp_data_in   = '{ctrl1_x: ka_x, ctrl1_y: ka_y, ctrl2_x: kq_x, ctrl2_y: kq_y,
                              end_x: kq_x, end_y: kq_y, straight: 1'b1,
                              dropped: ovf_ff, last_segment: 1'b1};
            cnt_in        = '0;
            ovf_in        = 1'b0;
            state_in      = ST_IDLE;
         end
         ST_FWD_RD: begin
            k_raddr   = row_ff;
            div_start = 1'b1;
            state_in  = ST_FWD_KI;
         end
         ST_FWD_KI: begin
            ka_in    = k_q;
            k_raddr  = row_ff + IDX_BITS'(1);
            state_in = ST_FWD_KN;
         end
         ST_FWD_KN: begin
            vx_in    = rhs_x;
            vy_in    = rhs_y;
            state_in = ST_FWD_DIV;
         end
         ST_FWD_DIV: begin
            if (div_done) begin
               coef_in  = recip;
               state_in = ST_FWD_MX;
            end
         end
         ST_FWD_MX: begin
            state_in = ST_FWD_MXW;
         end
         ST_FWD_MXW: begin
            if (mul_done) begin
               stx_in   = sat_p;
               state_in = ST_FWD_MY;
            end
         end
         ST_FWD_MY: begin
            state_in = ST_FWD_MYW;
         end
         ST_FWD_MYW: begin
            if (mul_done) begin
               s_we     = 1'b1;
               prevx_in = stx_ff;
               prevy_in = sat_p;
               cprev_in = coef_ff;
               if (last_row) begin
                  // The last swept value already is the last first control.
                  row_in   = n_ff - IDX_BITS'(2);
                  state_in = ST_BWD_RD;
               end else begin
                  row_in   = row_ff + IDX_BITS'(1);
                  state_in = ST_FWD_RD;
               end
            end
         end
         ST_BWD_RD: begin
            s_raddr  = row_ff;
            state_in = ST_BWD_MX;
         end
         ST_BWD_MX: begin
            coef_in  = s_coef;
            stx_in   = s_x;
            sty_in   = s_y;
            state_in = ST_BWD_MXW;
         end
         ST_BWD_MXW: begin
            if (mul_done) begin
               newx_in  = sat_acc(acc_to_wide(stx_ff) - mul_p);
               state_in = ST_BWD_MY;
            end
         end
         ST_BWD_MY: begin
            state_in = ST_BWD_MYW;
         end
         ST_BWD_MYW: begin
            if (mul_done) begin
               s_we     = 1'b1;
               s_wdata  = {coef_ff, newx_ff, sat_acc(acc_to_wide(sty_ff) - mul_p)};
               prevx_in = newx_ff;
               prevy_in = sat_acc(acc_to_wide(sty_ff) - mul_p);
               if (first_row) begin
                  state_in = ST_EM_RD0;
               end else begin
                  row_in   = row_ff - IDX_BITS'(1);
                  state_in = ST_BWD_RD;
               end
            end
         end
         ST_EM_RD0: begin
            s_raddr  = '0;
            state_in = ST_EM_CAP;
         end
         ST_EM_CAP: begin
            prevx_in = s_x;
            prevy_in = s_y;
            row_in   = '0;
            state_in = ST_EM_RD;
         end
         ST_EM_RD: begin
            s_raddr  = row_ff + IDX_BITS'(1);
            k_raddr  = row_ff + IDX_BITS'(1);
            state_in = ST_EM_OUT;
         end
         ST_EM_OUT: begin
            rsp_strobe_in = 1'b1;
            rsp_data_in.ctrl1_x = sat_coord(round_away(acc_to_wide(prevx_ff), 8));
            rsp_data_in.ctrl1_y = sat_coord(round_away(acc_to_wide(prevy_ff), 8));
            if (last_row) begin
               rsp_data_in.ctrl2_x = sat_coord(round_away(
                  knot_to_wide(kq_x) + acc_to_wide(prevx_ff), 9));
               rsp_data_in.ctrl2_y = sat_coord(round_away(
                  knot_to_wide(kq_y) + acc_to_wide(prevy_ff), 9));
            end else begin
               rsp_data_in.ctrl2_x = sat_coord(round_away(
                  (knot_to_wide(kq_x) <<< 1) - acc_to_wide(s_x), 8));
               rsp_data_in.ctrl2_y = sat_coord(round_away(
                  (knot_to_wide(kq_y) <<< 1) - acc_to_wide(s_y), 8));
            end
            rsp_data_in.end_x        = kq_x;
            rsp_data_in.end_y        = kq_y;
            rsp_data_in.straight     = 1'b0;
            rsp_data_in.dropped      = ovf_ff;
            rsp_data_in.last_segment = last_row;
            prevx_in = s_x;
            prevy_in = s_y;
            if (last_row) begin
               cnt_in   = '0;
               ovf_in   = 1'b0;
               state_in = ST_IDLE;
            end else begin
               row_in   = row_ff + IDX_BITS'(1);
               state_in = ST_EM_RD;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         cnt_ff        <= '0;
         ovf_ff        <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         ovf_ff        <= ovf_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      n_ff        <= n_in;
      row_ff      <= row_in;
      ka_ff       <= ka_in;
      vx_ff       <= vx_in;
      vy_ff       <= vy_in;
      coef_ff     <= coef_in;
      cprev_ff    <= cprev_in;
      prevx_ff    <= prevx_in;
      prevy_ff    <= prevy_in;
      stx_ff      <= stx_in;
      sty_ff      <= sty_in;
      newx_ff     <= newx_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Knot store: written while loading, read by the sweeps and the emitter.
   bzs_ram #(
      .WIDTH (KNOT_W),
      .DEPTH (MAX_KNOTS)
   ) u_knot_ram (
      .clock   (clock),
      .wr_en   (k_we),
      .wr_addr (cnt_ff[IDX_BITS-1:0]),
      .wr_data ({req_data.knot_x, req_data.knot_y}),
      .rd_addr (k_raddr),
      .rd_data (k_q)
   );

   // Sweep store: coefficient and swept target per row, overwritten in place
   // by the first control points during the backward sweep. A row is always
   // written before a later state reads it, so no forwarding is needed.
   bzs_ram #(
      .WIDTH (SOLVE_W),
      .DEPTH (MAX_KNOTS)
   ) u_solve_ram (
      .clock   (clock),
      .wr_en   (s_we),
      .wr_addr (row_ff),
      .wr_data (s_wdata),
      .rd_addr (s_raddr),
      .rd_data (s_q)
   );

   bzs_recip u_recip (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .pivot (pivot),
      .done  (div_done),
      .recip (recip)
   );

   bzs_mul u_mul (
      .clock (clock),
      .reset (reset),
      .start (mul_start),
      .a     (mul_a),
      .coef  (mul_coef),
      .done  (mul_done),
      .p     (mul_p)
   );

   assign busy       = state_ff != ST_IDLE;
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

   // The last knot always raises busy.
   a_solve_starts: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_data.last_knot |=> busy)
      else $error("solve did not start after the last knot");

   // The final segment beat leaves the knot count and overflow mark cleared.
   a_final_clears: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_data.last_segment |-> cnt_ff == '0 && !ovf_ff)
      else $error("curve state not cleared with the final segment");

   // More segments follow a beat that is not the last one.
   a_more_follow: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_data.last_segment |-> busy)
      else $error("block idle before the final segment");

   // Forward rows stay inside the system.
   a_row_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_FWD_RD |-> row_ff < n_ff)
      else $error("forward sweep row out of range");

endmodule

`default_nettype wire
